@@ design/slfd_pkg.sv @@
// Shared constants, types and helper functions of the scan line framer.
package slfd_pkg;

  // Line buffer sizing.
  localparam int LINE_LIMIT    = 64;
  localparam int BARCODE_LIMIT = 32;
  localparam int CAP           = LINE_LIMIT - 1;
  localparam int CNT_W         = $clog2(LINE_LIMIT);
  localparam int ADDR_W        = $clog2(CAP);

  // Field widths.
  localparam int BYTE_W  = 8;
  localparam int TIME_W  = 48;
  localparam int DEB_W   = 16;
  localparam int MULT_W  = 10;
  localparam int THR_W   = DEB_W + MULT_W;
  localparam int CFG_W   = 16;
  localparam int CFG_A_W = 2;

  localparam logic [MULT_W-1:0] MS_TO_US = MULT_W'(1000);
  localparam int                MIN_LEN  = 4;
  localparam int                PFX_LEN  = 5;

  // Item kinds.
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] CFG_RX_READY    = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_SCAN_ON     = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_DEBOUNCE_MS = 2'd2;

  // Characters.
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_byte;
    logic clear_line;
    logic start;
    logic eval;
    logic idx_clr;
    logic idx_inc;
    logic cmp_check;
    logic commit;
    logic emit_load;
  } slfd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rx_ready;
    logic scan_on;
    logic is_term;
    logic overflowed;
    logic count_zero;
    logic plausible;
    logic len_match;
    logic idx_last;
    logic byte_eq;
    logic dup;
    logic out_free;
  } slfd_status_t;

  // Letters, digits, dash and underscore are legal code characters.
  function automatic logic char_ok(input logic [BYTE_W-1:0] c);
    logic res;
    res = ((c >= 8'h30) && (c <= 8'h39)) ||
          ((c >= 8'h41) && (c <= 8'h5A)) ||
          ((c >= 8'h61) && (c <= 8'h7A)) ||
          (c == CH_DASH) || (c == CH_UNDER);
    return res;
  endfunction

  // Characters of the setup code prefix "GMS1_".
  function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] pos);
    logic [BYTE_W-1:0] res;
    unique case (pos)
      3'd0:    res = 8'h47;
      3'd1:    res = 8'h4D;
      3'd2:    res = 8'h53;
      3'd3:    res = 8'h31;
      3'd4:    res = CH_UNDER;
      default: res = 8'h00;
    endcase
    return res;
  endfunction

endpackage

@@ design/slfd_datapath.sv @@
// Datapath: configuration registers, line and previous-code memories, checks and output register.
module slfd_datapath
  import slfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_A_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic [TIME_W-1:0]   now_us_i,
  input  slfd_cmd_t           cmd_i,
  output slfd_status_t        sts_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [BYTE_W-1:0]   code_char_o,
  output logic                last_char_o
);

  localparam logic [CNT_W-1:0] CAP_C     = CNT_W'(CAP);
  localparam logic [CNT_W-1:0] MIN_LEN_C = CNT_W'(MIN_LEN);
  localparam logic [CNT_W-1:0] PFX_LEN_C = CNT_W'(PFX_LEN);
  localparam logic [CNT_W:0]   BC_LIM_C  = (CNT_W + 1)'(BARCODE_LIMIT);

  logic                rx_ready_q, scan_on_q;
  logic [DEB_W-1:0]    debounce_q;

  logic [CNT_W-1:0]    count_q, count_d;
  logic                ovf_q, ovf_d;
  logic                chars_ok_q, chars_ok_d;
  logic                prefix_ok_q, prefix_ok_d;

  logic [CNT_W-1:0]    len_q;
  logic [TIME_W-1:0]   now_q;
  logic                same_q;
  logic [CNT_W-1:0]    idx_q;
  logic [TIME_W-1:0]   elapsed_q;
  logic [THR_W-1:0]    thr_q;

  logic [CNT_W-1:0]    prev_len_q;
  logic [TIME_W-1:0]   prev_time_q;

  logic [BYTE_W-1:0]   line_mem [CAP];
  logic [BYTE_W-1:0]   prev_mem [CAP];
  logic [BYTE_W-1:0]   rd_line_q, rd_prev_q;

  logic                out_valid_q;
  logic [BYTE_W-1:0]   out_char_q;
  logic                out_last_q;

  logic                has_room;
  logic                store_en;
  logic                setup_code;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_ready_q <= 1'b0;
      scan_on_q  <= 1'b1;
      debounce_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RX_READY:    rx_ready_q <= cfg_wdata_i[0];
        CFG_SCAN_ON:     scan_on_q  <= cfg_wdata_i[0];
        CFG_DEBOUNCE_MS: debounce_q <= cfg_wdata_i[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  assign has_room = (count_q < CAP_C);
  assign store_en = cmd_i.take_byte && has_room;

  // Line collection. The character and prefix checks are kept up to date as bytes arrive.
  always_comb begin
    count_d     = count_q;
    ovf_d       = ovf_q;
    chars_ok_d  = chars_ok_q;
    prefix_ok_d = prefix_ok_q;
    if (cmd_i.take_byte) begin
      if (has_room) begin
        count_d    = count_q + CNT_W'(1);
        chars_ok_d = ((count_q == '0) || chars_ok_q) && char_ok(data_byte_i);
        if (count_q < PFX_LEN_C) begin
          prefix_ok_d = ((count_q == '0) || prefix_ok_q) &&
                        (data_byte_i == prefix_char(count_q[2:0]));
        end
      end else begin
        ovf_d = 1'b1;
      end
    end else if (cmd_i.clear_line) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      chars_ok_q  <= 1'b0;
      prefix_ok_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      chars_ok_q  <= chars_ok_d;
      prefix_ok_q <= prefix_ok_d;
    end
  end

  // Finished-line working registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      same_q      <= 1'b0;
      idx_q       <= '0;
      prev_len_q  <= '0;
      prev_time_q <= '0;
    end else begin
      if (cmd_i.start) begin
        len_q  <= count_q;
        same_q <= 1'b1;
      end else if (cmd_i.cmp_check && (rd_line_q != rd_prev_q)) begin
        same_q <= 1'b0;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + CNT_W'(1);
      end
      if (cmd_i.commit) begin
        prev_len_q  <= len_q;
        prev_time_q <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      now_q <= now_us_i;
    end
    if (cmd_i.eval) begin
      elapsed_q <= now_q - prev_time_q;
      thr_q     <= THR_W'(debounce_q) * THR_W'(MS_TO_US);
    end
  end

  // Line store: written at the fill count, read at the working index.
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      line_mem[count_q[ADDR_W-1:0]] <= data_byte_i;
    end
    rd_line_q <= line_mem[idx_q[ADDR_W-1:0]];
  end

  // Previous code: copied character by character while a new code is sent out.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      prev_mem[idx_q[ADDR_W-1:0]] <= rd_line_q;
    end
    rd_prev_q <= prev_mem[idx_q[ADDR_W-1:0]];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_char_q <= rd_line_q;
      out_last_q <= sts_o.idx_last;
    end
  end

  assign setup_code = prefix_ok_q && (count_q >= PFX_LEN_C);

  always_comb begin
    sts_o             = '0;
    sts_o.rx_ready    = rx_ready_q;
    sts_o.scan_on     = scan_on_q;
    sts_o.is_term     = (data_byte_i == CH_CR) || (data_byte_i == CH_LF);
    sts_o.overflowed  = ovf_q;
    sts_o.count_zero  = (count_q == '0);
    sts_o.plausible   = (count_q >= MIN_LEN_C) && chars_ok_q &&
                        (setup_code || ({1'b0, count_q} < BC_LIM_C));
    sts_o.len_match   = (len_q == prev_len_q);
    sts_o.idx_last    = (idx_q == (len_q - CNT_W'(1)));
    sts_o.byte_eq     = (rd_line_q == rd_prev_q);
    sts_o.dup         = same_q && (len_q == prev_len_q) &&
                        (elapsed_q < TIME_W'(thr_q));
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign code_char_o = out_char_q;
  assign last_char_o = out_last_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CAP_C)
    else $error("line count beyond buffer capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_i.emit_load |-> sts_o.out_free)
    else $error("output register loaded while still holding a character");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> prev_len_q == $past(len_q))
    else $error("previous code length not updated on commit");

  assert property (@(posedge clk_i) disable iff (!rst_ni) $rose(ovf_q) |-> count_q == CAP_C)
    else $error("overflow flagged with room left in the line buffer");
`endif

endmodule

@@ design/slfd_ctrl.sv @@
// Controller state machine: byte handling, duplicate check sequencing and code output.
module slfd_ctrl
  import slfd_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          cmd_i,
  input  slfd_status_t  sts_i,
  output slfd_cmd_t     cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EVAL   = 3'd1;
  localparam logic [2:0] ST_CMP_RD = 3'd2;
  localparam logic [2:0] ST_CMP_CK = 3'd3;
  localparam logic [2:0] ST_DECIDE = 3'd4;
  localparam logic [2:0] ST_EMIT_RD = 3'd5;
  localparam logic [2:0] ST_EMIT_WR = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;
  logic       is_byte;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign is_byte    = (cmd_i == CMD_BYTE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (is_byte && !sts_i.rx_ready) begin
            // Bytes are dropped while the receiver is off.
          end else if (is_byte && !sts_i.is_term) begin
            cmd_o.take_byte = 1'b1;
          end else if (sts_i.overflowed) begin
            cmd_o.clear_line = 1'b1;
          end else if (!sts_i.count_zero) begin
            cmd_o.clear_line = 1'b1;
            if (sts_i.scan_on && sts_i.plausible) begin
              cmd_o.start = 1'b1;
              state_d     = ST_EVAL;
            end
          end
        end
      end
      ST_EVAL: begin
        cmd_o.eval    = 1'b1;
        cmd_o.idx_clr = 1'b1;
        state_d       = sts_i.len_match ? ST_CMP_RD : ST_DECIDE;
      end
      ST_CMP_RD: begin
        state_d = ST_CMP_CK;
      end
      ST_CMP_CK: begin
        cmd_o.cmp_check = 1'b1;
        if (!sts_i.byte_eq || sts_i.idx_last) begin
          state_d = ST_DECIDE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = ST_CMP_RD;
        end
      end
      ST_DECIDE: begin
        cmd_o.commit  = 1'b1;
        cmd_o.idx_clr = 1'b1;
        state_d       = sts_i.dup ? ST_IDLE : ST_EMIT_RD;
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.idx_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ design/scan_line_framer_dedup_core.sv @@
// Top level of the scan line framer with duplicate suppression.
//
// Input channel (in_valid_i / in_stall_o): one transfer carries a scanner byte
// (cmd_i = 0) or an idle flush (cmd_i = 1) with its microsecond time stamp.
// Output channel (out_valid_o / out_stall_i): one transfer per character of an
// accepted code, last_char_o marking the final one.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_index_i
// (0 receiver ready, 1 scan enable, 2 debounce window in ms). The user must
// write only while idle; the block itself does not enforce this.
// Plain bytes are taken one per cycle. A line end starts a sequence that holds
// the input off: a setup state, then a read and a check state per character to
// compare against the previous code when the lengths match, a decide state,
// then a read and a write state per emitted character. The single read port of
// each line memory is why each character needs its own read state.
// A stalled receiver holds the output register and the emit sequence waits;
// the next input item is accepted once the last character is registered.
// Reset clears the line count, the previous-code length and time, and the
// registers to their defaults; no clearing pass is needed.
module scan_line_framer_dedup_core
  import slfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [BYTE_W-1:0]   data_byte_i,
  input  logic [TIME_W-1:0]   now_us_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [BYTE_W-1:0]   code_char_o,
  output logic                last_char_o,
  input  logic                cfg_we_i,
  input  logic [CFG_A_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  slfd_cmd_t    dp_cmd;
  slfd_status_t dp_sts;

  slfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  slfd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .data_byte_i (data_byte_i),
    .now_us_i    (now_us_i),
    .cmd_i       (dp_cmd),
    .sts_o       (dp_sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .code_char_o (code_char_o),
    .last_char_o (last_char_o)
  );

endmodule

@@ sim/scan_line_framer_dedup_core_checker.sv @@
// Checker for the scan line framer: tracks both channels, predicts each code and compares.
`timescale 1ns / 1ps

module scan_line_framer_dedup_core_checker
  import slfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               cmd_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  input  logic [TIME_W-1:0]  now_us_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [BYTE_W-1:0]  code_char_i,
  input  logic               last_char_i,
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int              MIN_CODE_LEN = 4;
  localparam int              PREFIX_LEN   = 5;
  localparam logic [39:0]     SETUP_PREFIX = "GMS1_";
  localparam logic [TIME_W-1:0] US_PER_MS  = TIME_W'(1000);
  localparam int              REPORT_MAX   = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } code_beat_t;

  code_beat_t        code_beats[$];

  logic [BYTE_W-1:0] line_buf [CAP];
  int unsigned       fill_len;
  logic              line_ovf;
  logic [BYTE_W-1:0] held_code [CAP];
  int unsigned       held_len;
  logic [TIME_W-1:0] held_time;

  logic              rx_on;
  logic              scan_on;
  logic [DEB_W-1:0]  window_ms;
  int                mismatches;

  function automatic logic legal_code_char(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] folded;
    folded = c | 8'h20;
    return (c >= "0" && c <= "9") || (folded >= "a" && folded <= "z") ||
           c == CH_DASH || c == CH_UNDER;
  endfunction

  function automatic logic line_is_code(input int unsigned n);
    logic setup;
    logic ok;
    if (n < MIN_CODE_LEN || n >= LINE_LIMIT || n > CAP) return 1'b0;
    setup = (n >= PREFIX_LEN);
    for (int i = 0; i < PREFIX_LEN; i++) begin
      if (setup && line_buf[i] != SETUP_PREFIX[8*(PREFIX_LEN-1-i) +: 8]) setup = 1'b0;
    end
    // Setup codes are bounded by the line buffer only.
    if (!setup && n >= BARCODE_LIMIT) return 1'b0;
    ok = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!legal_code_char(line_buf[i])) ok = 1'b0;
    end
    return ok;
  endfunction

  task automatic close_line(input logic [TIME_W-1:0] stamp);
    int unsigned       n;
    logic              same;
    logic              suppressed;
    logic [TIME_W-1:0] elapsed;
    n = fill_len;
    fill_len = 0;
    if (!scan_on || !line_is_code(n)) return;
    same = (n == held_len);
    for (int i = 0; i < n; i++) begin
      if (same && line_buf[i] != held_code[i]) same = 1'b0;
    end
    // The timer wraps, so a stamp earlier than the stored one is a long gap.
    elapsed = stamp - held_time;
    suppressed = same && (elapsed < TIME_W'(window_ms) * US_PER_MS);
    for (int i = 0; i < n; i++) held_code[i] = line_buf[i];
    held_len = n;
    held_time = stamp;
    if (suppressed) return;
    for (int i = 0; i < n; i++) begin
      code_beats.push_back('{ch: line_buf[i], last: (i == n - 1)});
    end
  endtask

  task automatic take_transfer(input logic kind, input logic [BYTE_W-1:0] c,
                               input logic [TIME_W-1:0] stamp);
    if (kind == CMD_BYTE) begin
      if (!rx_on) return;
      if (c != CH_CR && c != CH_LF) begin
        if (fill_len < CAP) begin
          line_buf[fill_len] = c;
          fill_len++;
        end else begin
          line_ovf = 1'b1;
        end
        return;
      end
    end
    if (line_ovf) begin
      fill_len = 0;
      line_ovf = 1'b0;
      return;
    end
    if (fill_len == 0) return;
    close_line(stamp);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    code_beat_t want;
    if (!rst_ni) begin
      code_beats.delete();
      fill_len = 0;
      line_ovf = 1'b0;
      held_len = 0;
      held_time = '0;
      rx_on = 1'b0;
      scan_on = 1'b1;
      window_ms = '0;
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_RX_READY:    rx_on = cfg_wdata_i[0];
          CFG_SCAN_ON:     scan_on = cfg_wdata_i[0];
          CFG_DEBOUNCE_MS: window_ms = cfg_wdata_i[DEB_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (code_beats.size() == 0) begin
          if (mismatches < REPORT_MAX) begin
            $display("%0t: unexpected character %h (last %b) with no code pending",
                     $realtime, code_char_i, last_char_i);
          end
          mismatches++;
        end else begin
          want = code_beats.pop_front();
          if (want.ch !== code_char_i || want.last !== last_char_i) begin
            if (mismatches < REPORT_MAX) begin
              $display("%0t: code mismatch: expected char %h last %b, got char %h last %b",
                       $realtime, want.ch, want.last, code_char_i, last_char_i);
            end
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) take_transfer(cmd_i, data_byte_i, now_us_i);
      fail_count_o <= mismatches;
      pending_o <= code_beats.size();
    end
  end

endmodule

@@ sim/scan_line_framer_dedup_core_tb.sv @@
// Testbench top for the scan line framer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module scan_line_framer_dedup_core_tb;
  import slfd_pkg::*;

  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 300;
  localparam int          RESET_CYCLES   = 11;
  localparam int          PHASE_ITEMS    = 18;
  localparam int          PHASE_COUNT    = 4;
  localparam logic [39:0] SETUP_PREFIX   = "GMS1_";

  typedef enum int {END_CR, END_LF, END_FLUSH, END_NONE} line_end_e;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               cmd = CMD_BYTE;
  logic [BYTE_W-1:0]  data_byte = '0;
  logic [TIME_W-1:0]  now_us = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [BYTE_W-1:0]  code_char;
  logic               last_char;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_index = CFG_RX_READY;
  logic [CFG_W-1:0]   cfg_wdata = '0;
  int                 fail_count;
  int                 pending;

  logic [TIME_W-1:0]  clock_us = '0;
  int                 sender_idle_pct = 0;
  int                 stall_pct = 0;
  int                 sent_items = 0;
  int                 idle_cycles = 0;
  logic [BYTE_W-1:0]  line_bytes[$];

  always #5 clk = ~clk;

  scan_line_framer_dedup_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .cmd_i       (cmd),
    .data_byte_i (data_byte),
    .now_us_i    (now_us),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .code_char_o (code_char),
    .last_char_o (last_char),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  scan_line_framer_dedup_core_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .cmd_i        (cmd),
    .data_byte_i  (data_byte),
    .now_us_i     (now_us),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .code_char_i  (code_char),
    .last_char_i  (last_char),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  // The watchdog restarts on every transfer in either direction.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(input logic kind, input logic [BYTE_W-1:0] value);
    while (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    clock_us = clock_us + TIME_W'($urandom_range(0, 40));
    in_valid <= 1'b1;
    cmd <= kind;
    data_byte <= value;
    now_us <= clock_us;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
  endtask

  task automatic send_line(input line_end_e how);
    foreach (line_bytes[i]) send_item(CMD_BYTE, line_bytes[i]);
    case (how)
      END_CR:    send_item(CMD_BYTE, CH_CR);
      END_LF:    send_item(CMD_BYTE, CH_LF);
      END_FLUSH: send_item(CMD_FLUSH, BYTE_W'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  function automatic logic [BYTE_W-1:0] random_legal_char();
    int k;
    k = $urandom_range(0, 63);
    if (k < 10) return "0" + BYTE_W'(k);
    if (k < 36) return "A" + BYTE_W'(k - 10);
    if (k < 62) return "a" + BYTE_W'(k - 36);
    return (k == 62) ? CH_DASH : CH_UNDER;
  endfunction

  task automatic make_code(input int len, input logic setup);
    line_bytes.delete();
    if (setup) begin
      for (int i = 0; i < 5; i++) line_bytes.push_back(SETUP_PREFIX[8*(4-i) +: 8]);
    end
    while (line_bytes.size() < len) line_bytes.push_back(random_legal_char());
  endtask

  task automatic make_text(input string s);
    line_bytes.delete();
    for (int i = 0; i < s.len(); i++) line_bytes.push_back(s[i]);
  endtask

  // Holds the input off until every pending character is out and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic rx, input logic scan, input logic [DEB_W-1:0] win);
    cfg_we <= 1'b1;
    cfg_index <= CFG_RX_READY;
    cfg_wdata <= CFG_W'(rx);
    @(posedge clk);
    cfg_index <= CFG_SCAN_ON;
    cfg_wdata <= CFG_W'(scan);
    @(posedge clk);
    cfg_index <= CFG_DEBOUNCE_MS;
    cfg_wdata <= CFG_W'(win);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_random_line();
    int r;
    int n;
    int pos;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      make_code($urandom_range(4, 34), 1'b0);
    end else if (r < 55) begin
      // Resend the previous line unchanged to provoke duplicates.
    end else if (r < 63) begin
      make_code($urandom_range(5, ($urandom_range(0, 3) == 0) ? 63 : 20), 1'b1);
    end else if (r < 72) begin
      make_code($urandom_range(4, 20), 1'b0);
      pos = $urandom_range(0, line_bytes.size() - 1);
      line_bytes[pos] = BYTE_W'($urandom_range(0, 255));
    end else if (r < 80) begin
      make_code($urandom_range(1, 3), 1'b0);
    end else if (r < 86) begin
      make_code($urandom_range(64, 70), 1'(r));
    end else if (r < 93) begin
      line_bytes.delete();
      n = $urandom_range(1, 10);
      repeat (n) line_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    end else begin
      line_bytes.delete();
    end
    if ($urandom_range(0, 7) == 0) clock_us = clock_us + TIME_W'($urandom_range(0, 5000));
    send_line(line_end_e'($urandom_range(0, 2)));
  endtask

  initial begin
    int phase_end;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Receiver not ready after reset: bytes are dropped, a flush finds nothing.
    make_text("AB");
    send_line(END_CR);
    send_item(CMD_FLUSH, 8'hFF);
    settle();
    configure(1'b1, 1'b1, 16'd0);

    send_item(CMD_BYTE, CH_CR);
    send_item(CMD_FLUSH, 8'h00);
    make_text("AB-_");
    send_line(END_CR);
    // With a zero window the same code goes out again.
    send_line(END_LF);
    make_text("abc");
    send_line(END_LF);
    make_text("09AZaz");
    send_line(END_CR);
    make_text("AB@[`{/:");
    send_line(END_CR);
    make_code(8, 1'b0);
    line_bytes[3] = 8'hFF;
    send_line(END_LF);
    make_code(8, 1'b0);
    line_bytes[5] = 8'h00;
    line_bytes[0] = 8'h80;
    send_line(END_CR);
    make_code(31, 1'b0);
    send_line(END_FLUSH);
    make_code(32, 1'b0);
    send_line(END_CR);
    make_text("GMS1_");
    send_line(END_CR);
    make_text("GMS1-ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789");
    send_line(END_LF);
    make_code(63, 1'b1);
    send_line(END_LF);
    make_code(64, 1'b1);
    send_line(END_CR);
    make_code(10, 1'b0);
    send_line(END_CR);

    // Longest window: repeats are swallowed, wrap and backward time are long gaps.
    settle();
    configure(1'b1, 1'b1, 16'hFFFF);
    make_text("DUP-01");
    send_line(END_CR);
    send_line(END_CR);
    make_text("DUP-02");
    send_line(END_LF);
    make_text("DUP-01");
    send_line(END_FLUSH);
    clock_us = '1 - TIME_W'(20);
    make_text("WRAP1");
    send_line(END_CR);
    send_line(END_CR);
    clock_us = clock_us - TIME_W'(5000);
    send_line(END_CR);

    // Scanning off: lines vanish and the stored code survives.
    settle();
    configure(1'b1, 1'b0, 16'hFFFF);
    send_line(END_CR);
    make_text("OTHER1");
    send_line(END_LF);
    settle();
    configure(1'b1, 1'b1, 16'hFFFF);
    make_text("WRAP1");
    send_line(END_CR);

    // A flush still closes a line once the receiver is no longer ready.
    make_text("HOLD1");
    send_line(END_NONE);
    settle();
    configure(1'b0, 1'b1, 16'hFFFF);
    send_item(CMD_BYTE, "X");
    send_item(CMD_BYTE, CH_LF);
    send_item(CMD_FLUSH, 8'h5A);

    for (int p = 0; p < PHASE_COUNT; p++) begin
      settle();
      case (p % 4)
        0: begin sender_idle_pct = 0;  stall_pct = 0;  end
        1: begin sender_idle_pct = 61; stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  stall_pct = 61; end
        default: begin sender_idle_pct = 6; stall_pct = 6; end
      endcase
      case (p)
        0: configure(1'b1, 1'b1, 16'd0);
        1: configure(1'b1, 1'b1, 16'd1);
        2: configure(1'b1, 1'b1, DEB_W'($urandom_range(1, 5)));
        default: configure(1'b1, 1'b1, DEB_W'($urandom_range(0, 65535)));
      endcase
      if (p % 2 == 1) clock_us = TIME_W'({$urandom(), $urandom()});
      phase_end = sent_items + PHASE_ITEMS;
      while (sent_items < phase_end) send_random_line();
    end

    sender_idle_pct = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ scan_line_framer_dedup_core.f @@
design/slfd_pkg.sv
design/slfd_datapath.sv
design/slfd_ctrl.sv
design/scan_line_framer_dedup_core.sv
sim/scan_line_framer_dedup_core_checker.sv
sim/scan_line_framer_dedup_core_tb.sv
